### hw/rtl/psd_pkg.sv
package psd_pkg;

  localparam logic [7:0] OP_PROTO            = 8'h80;
  localparam logic [7:0] OP_FRAME            = 8'h95;
  localparam logic [7:0] OP_SHORT_BINUNICODE = 8'h8c;
  localparam logic [7:0] OP_BINUNICODE8      = 8'h8d;
  localparam logic [7:0] OP_BINUNICODE       = 8'h58;
  localparam logic [7:0] MIN_FRAME_VERSION   = 8'd4;

  localparam logic [3:0] FRAME_LEN_BYTES = 4'd8;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_MISSING_PROTO = 3'd1;
  localparam logic [2:0] ST_END_BEFORE_OP = 3'd2;
  localparam logic [2:0] ST_TRUNC_LENGTH  = 3'd3;
  localparam logic [2:0] ST_OVERRUN       = 3'd4;
  localparam logic [2:0] ST_BAD_OPCODE    = 3'd5;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       string_end;
    logic [2:0] status;
    logic [7:0] bad_opcode;
  } result_t;

endpackage

### hw/rtl/psd_core.sv
module psd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                message_end,
  output logic                res_valid,
  output psd_pkg::result_t    res
);

  localparam logic [2:0] PH_PROTO   = 3'd0;
  localparam logic [2:0] PH_VER     = 3'd1;
  localparam logic [2:0] PH_FIRSTOP = 3'd2;
  localparam logic [2:0] PH_FRAME   = 3'd3;
  localparam logic [2:0] PH_STROP   = 3'd4;
  localparam logic [2:0] PH_LEN     = 3'd5;
  localparam logic [2:0] PH_PAY     = 3'd6;
  localparam logic [2:0] PH_SKIP    = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [7:0]  proto_version, proto_version_next;
  logic [3:0]  byte_counter, byte_counter_next;
  logic [3:0]  length_bytes_needed, length_bytes_needed_next;
  logic [63:0] length_or_remaining, length_or_remaining_next;

  logic [3:0]  cnt_inc;
  logic [63:0] len_merged;
  logic [63:0] rem_dec;
  logic        do_strop;
  logic        do_clear;

  assign cnt_inc = byte_counter + 4'd1;

  always_comb begin
    len_merged = length_or_remaining;
    len_merged[{byte_counter[2:0], 3'b000} +: 8] =
      length_or_remaining[{byte_counter[2:0], 3'b000} +: 8] | data_byte;
  end

  assign rem_dec = (length_or_remaining != 64'd0) ? length_or_remaining - 64'd1
                                                  : length_or_remaining;

  always_comb begin
    phase_next               = phase;
    proto_version_next       = proto_version;
    byte_counter_next        = byte_counter;
    length_bytes_needed_next = length_bytes_needed;
    length_or_remaining_next = length_or_remaining;
    res_valid                = 1'b0;
    res                      = '0;
    do_strop                 = 1'b0;
    do_clear                 = 1'b0;

    case (phase)
      PH_PROTO: begin
        if (data_byte != psd_pkg::OP_PROTO || message_end) begin
          res_valid  = 1'b1;
          res.status = psd_pkg::ST_MISSING_PROTO;
        end else begin
          phase_next = PH_VER;
        end
      end
      PH_VER: begin
        proto_version_next = data_byte;
        if (message_end) begin
          res_valid  = 1'b1;
          res.status = psd_pkg::ST_END_BEFORE_OP;
        end else begin
          phase_next = PH_FIRSTOP;
        end
      end
      PH_FIRSTOP: begin
        if (proto_version >= psd_pkg::MIN_FRAME_VERSION &&
            data_byte == psd_pkg::OP_FRAME) begin
          if (message_end) begin
            res_valid  = 1'b1;
            res.status = psd_pkg::ST_END_BEFORE_OP;
          end else begin
            length_bytes_needed_next = psd_pkg::FRAME_LEN_BYTES;
            byte_counter_next        = 4'd0;
            phase_next               = PH_FRAME;
          end
        end else begin
          do_strop = 1'b1;
        end
      end
      PH_FRAME: begin
        byte_counter_next = cnt_inc;
        if (message_end) begin
          res_valid  = 1'b1;
          res.status = psd_pkg::ST_END_BEFORE_OP;
        end else if (cnt_inc >= length_bytes_needed) begin
          phase_next = PH_STROP;
        end
      end
      PH_STROP: begin
        do_strop = 1'b1;
      end
      PH_LEN: begin
        length_or_remaining_next = len_merged;
        byte_counter_next        = cnt_inc;
        if (cnt_inc < length_bytes_needed) begin
          if (message_end) begin
            res_valid  = 1'b1;
            res.status = psd_pkg::ST_TRUNC_LENGTH;
          end
        end else if (len_merged == 64'd0) begin
          res_valid      = 1'b1;
          res.string_end = 1'b1;
        end else if (message_end) begin
          res_valid  = 1'b1;
          res.status = psd_pkg::ST_OVERRUN;
        end else begin
          phase_next = PH_PAY;
        end
      end
      PH_PAY: begin
        length_or_remaining_next = rem_dec;
        res_valid                = 1'b1;
        if (rem_dec == 64'd0) begin
          res.payload_byte = data_byte;
          res.byte_valid   = 1'b1;
          res.string_end   = 1'b1;
        end else if (message_end) begin
          res.status = psd_pkg::ST_OVERRUN;
        end else begin
          res.payload_byte = data_byte;
          res.byte_valid   = 1'b1;
        end
      end
      default: begin
        if (message_end) do_clear = 1'b1;
      end
    endcase

    if (do_strop) begin
      if (data_byte != psd_pkg::OP_SHORT_BINUNICODE &&
          data_byte != psd_pkg::OP_BINUNICODE &&
          data_byte != psd_pkg::OP_BINUNICODE8) begin
        res_valid      = 1'b1;
        res.status     = psd_pkg::ST_BAD_OPCODE;
        res.bad_opcode = data_byte;
      end else if (message_end) begin
        res_valid  = 1'b1;
        res.status = psd_pkg::ST_TRUNC_LENGTH;
      end else begin
        if (data_byte == psd_pkg::OP_SHORT_BINUNICODE) begin
          length_bytes_needed_next = 4'd1;
        end else if (data_byte == psd_pkg::OP_BINUNICODE) begin
          length_bytes_needed_next = 4'd4;
        end else begin
          length_bytes_needed_next = 4'd8;
        end
        byte_counter_next        = 4'd0;
        length_or_remaining_next = 64'd0;
        phase_next               = PH_LEN;
      end
    end

    // a result that is not a plain payload byte ends the string: skip to the end flag, or reset on it
    if (res_valid && !res.byte_valid) begin
      if (message_end) do_clear = 1'b1;
      else phase_next = PH_SKIP;
    end
    if (res_valid && res.string_end) begin
      if (message_end) do_clear = 1'b1;
      else phase_next = PH_SKIP;
    end

    if (do_clear) begin
      phase_next               = PH_PROTO;
      proto_version_next       = 8'd0;
      byte_counter_next        = 4'd0;
      length_bytes_needed_next = 4'd0;
      length_or_remaining_next = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_PROTO;
      proto_version       <= 8'd0;
      byte_counter        <= 4'd0;
      length_bytes_needed <= 4'd0;
      length_or_remaining <= 64'd0;
    end else if (step) begin
      phase               <= phase_next;
      proto_version       <= proto_version_next;
      byte_counter        <= byte_counter_next;
      length_bytes_needed <= length_bytes_needed_next;
      length_or_remaining <= length_or_remaining_next;
    end
  end

endmodule

### hw/rtl/psd_out_reg.sv
module psd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  psd_pkg::result_t load_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             room,
  output psd_pkg::result_t out_data
);

  logic             ov;
  psd_pkg::result_t data;

  // slot is free when empty or its request leaves this cycle
  assign room      = !ov || !out_stall;
  assign out_valid = ov;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (!out_stall) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= load_data;
  end

endmodule

### hw/rtl/pickle_string_stream_decoder_top.sv
// a result passes through the input register and then the result register
// before it is on the outputs
// throughput: one byte per cycle while the result register is not stalled;
// the decode step between the input register and the result register is combinational
// a byte that gives no result never waits on the result register
// rst is synchronous, active high; it clears both valid flags and the decoder state
module pickle_string_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       string_end,
  output logic [2:0] status,
  output logic [7:0] bad_opcode
);

  logic             iv;
  logic [7:0]       ib;
  logic             il;
  logic             room;
  logic             step;
  logic             res_valid;
  psd_pkg::result_t res;
  psd_pkg::result_t out_data;

  assign step     = iv && (room || !res_valid);
  assign in_stall = iv && res_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib <= data_byte;
      il <= message_end;
    end
  end

  psd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (ib),
    .message_end (il),
    .res_valid   (res_valid),
    .res         (res)
  );

  psd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .room      (room),
    .out_data  (out_data)
  );

  assign payload_byte = out_data.payload_byte;
  assign byte_valid   = out_data.byte_valid;
  assign string_end   = out_data.string_end;
  assign status       = out_data.status;
  assign bad_opcode   = out_data.bad_opcode;

endmodule

### hw/rtl/psd_checker.sv
module psd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       byte_valid,
  input logic       string_end,
  input logic [2:0] status,
  input logic [7:0] bad_opcode,
  input logic [7:0] payload_byte
);

  // a stalled result request stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_valid || string_end) |-> status == psd_pkg::ST_OK)
    else $error("string byte or end carries an error status");

  a_opcode_only_on_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != psd_pkg::ST_BAD_OPCODE |-> bad_opcode == 8'd0)
    else $error("bad_opcode set without bad opcode status");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> payload_byte == 8'd0)
    else $error("payload_byte nonzero without byte_valid");

endmodule

bind pickle_string_stream_decoder_top psd_checker u_psd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .byte_valid   (byte_valid),
  .string_end   (string_end),
  .status       (status),
  .bad_opcode   (bad_opcode),
  .payload_byte (payload_byte)
);
